// ===== hdl/hhpe_pkg.sv =====
// ----------------------------------------------------------------------------
// hhpe_pkg
// Types, codes and helpers for the HTTP host/port extractor.
// ----------------------------------------------------------------------------
package hhpe_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  host_byte;
    logic [15:0] port;
    logic        host_found;
    logic        port_saturated;
    logic        end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_TO_URL,
    PH_SEARCH,
    PH_HOST_SKIP,
    PH_HOST_NAME,
    PH_HOST_PORT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    URL_SCAN,
    URL_PORT,
    URL_DONE
  } url_phase_t;

  localparam logic        KIND_HOST    = 1'b0;
  localparam logic        KIND_SUMMARY = 1'b1;
  localparam logic [15:0] DEFAULT_PORT_RESET = 16'd80;
  localparam logic [2:0]  TAG_LEN = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [15:0] value;
    logic        live;
    logic        sat;
  } port_acc_t;

  function automatic logic [7:0] host_tag(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_LF;
      3'd1:    ch = 8'h48;  // 'H'
      3'd2:    ch = 8'h6f;  // 'o'
      3'd3:    ch = 8'h73;  // 's'
      3'd4:    ch = 8'h74;  // 't'
      3'd5:    ch = CH_COLON;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_host_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR ||
           c == CH_NUL || c == CH_COLON;
  endfunction

  // one port character: leading decimal digits accumulate, clamped at 65535
  function automatic port_acc_t port_char(input port_acc_t acc, input logic [7:0] c);
    port_acc_t  r;
    logic [19:0] v;
    r = acc;
    v = ({4'b0, acc.value} << 3) + ({4'b0, acc.value} << 1) + {16'b0, c[3:0]};
    if (acc.live) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        if (v > 20'd65535) begin
          r.value = 16'hffff;
          r.sat   = 1'b1;
        end else begin
          r.value = v[15:0];
        end
      end else begin
        r.live = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/http_host_port_extractor.sv =====
// ----------------------------------------------------------------------------
// http_host_port_extractor
// Streaming HTTP request parser: emits Host name bytes and a port summary.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle. Each Host name byte comes out as a host
// item; the final byte (last set) or a NUL byte adds a summary item carrying
// the port (Host header port, else URL port, else default_port) or zero when
// no host was seen. Parse state updates in the accepting cycle and results go
// into a four-entry output queue; input is stalled only while the queue has
// fewer than two free slots, so throughput is one byte per cycle as long as
// the output side keeps up. default_port is written through the cfg channel,
// which is always ready; write it only while the block is idle.
module http_host_port_extractor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hhpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hhpe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import hhpe_pkg::*;

  logic [15:0] default_port;
  phase_t      phase, phase_next;
  logic [2:0]  match_cnt, match_cnt_next;
  url_phase_t  url_phase, url_phase_next;
  port_acc_t   url_acc, url_acc_next;
  logic        url_seen, url_seen_next;
  port_acc_t   hdr_acc, hdr_acc_next;
  logic        hdr_seen, hdr_seen_next;
  logic        host_length_nonzero, host_length_nonzero_next;

  out_item_t   queue [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count;

  logic        take, is_nul, finish, active, emit;
  logic [7:0]  c;
  phase_t      eff_phase;
  out_item_t   host_item, summary_item;
  logic [2:0]  pushes;
  logic        pop;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;
  assign c         = in_data.byte_value;
  assign is_nul    = (c == CH_NUL);
  assign finish    = take && (is_nul || in_data.last);
  assign eff_phase = (phase == PH_TO_URL) ? PH_SEARCH : phase;
  assign active    = take && !is_nul && phase != PH_METHOD &&
                     !(phase == PH_TO_URL && !is_letter(c));

  // next parse state
  always_comb begin
    phase_next               = phase;
    match_cnt_next           = match_cnt;
    url_phase_next           = url_phase;
    url_acc_next             = url_acc;
    url_seen_next            = url_seen;
    hdr_acc_next             = hdr_acc;
    hdr_seen_next            = hdr_seen;
    host_length_nonzero_next = host_length_nonzero;

    if (take && !is_nul && phase == PH_METHOD && c == CH_SPACE) begin
      phase_next = PH_TO_URL;
    end

    if (active) begin
      phase_next = eff_phase;
      case (url_phase)
        URL_SCAN: begin
          if (c == CH_SPACE) url_phase_next = URL_DONE;
          else if (c == CH_COLON) url_phase_next = URL_PORT;
        end
        URL_PORT: begin
          if (c == CH_SPACE || c == CH_SLASH || c == CH_BSLASH) begin
            url_phase_next = URL_DONE;
          end else begin
            url_seen_next = 1'b1;
            url_acc_next  = port_char(url_acc, c);
          end
        end
        default: ;
      endcase

      case (eff_phase)
        PH_SEARCH: begin
          if (c == CH_LF) begin
            match_cnt_next = 3'd1;
          end else if (match_cnt < TAG_LEN && c == host_tag(match_cnt)) begin
            if (match_cnt + 3'd1 == TAG_LEN) begin
              match_cnt_next = 3'd0;
              phase_next     = PH_HOST_SKIP;
            end else begin
              match_cnt_next = match_cnt + 3'd1;
            end
          end else begin
            match_cnt_next = 3'd0;
          end
        end
        PH_HOST_SKIP: begin
          if (is_letter(c)) begin
            phase_next               = PH_HOST_NAME;
            host_length_nonzero_next = 1'b1;
          end
        end
        PH_HOST_NAME: begin
          if (is_host_delim(c)) begin
            phase_next = (c == CH_COLON) ? PH_HOST_PORT : PH_DONE;
          end else begin
            host_length_nonzero_next = 1'b1;
          end
        end
        PH_HOST_PORT: begin
          if (is_host_delim(c)) begin
            phase_next = PH_DONE;
          end else begin
            hdr_seen_next = 1'b1;
            hdr_acc_next  = port_char(hdr_acc, c);
          end
        end
        default: ;
      endcase
    end
  end

  // result items
  always_comb begin
    emit = active && ((eff_phase == PH_HOST_SKIP && is_letter(c)) ||
                      (eff_phase == PH_HOST_NAME && !is_host_delim(c)));

    host_item            = '0;
    host_item.kind       = KIND_HOST;
    host_item.host_byte  = c;
    host_item.end_of_run = !finish;

    summary_item            = '0;
    summary_item.kind       = KIND_SUMMARY;
    summary_item.end_of_run = 1'b1;
    if (host_length_nonzero_next) begin
      summary_item.host_found = 1'b1;
      if (hdr_seen_next) begin
        summary_item.port           = hdr_acc_next.value;
        summary_item.port_saturated = hdr_acc_next.sat;
      end else if (url_seen_next) begin
        summary_item.port           = url_acc_next.value;
        summary_item.port_saturated = url_acc_next.sat;
      end else begin
        summary_item.port = default_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      phase               <= PH_METHOD;
      match_cnt           <= 3'd0;
      url_phase           <= URL_SCAN;
      url_acc             <= '{value: 16'd0, live: 1'b1, sat: 1'b0};
      url_seen            <= 1'b0;
      hdr_acc             <= '{value: 16'd0, live: 1'b1, sat: 1'b0};
      hdr_seen            <= 1'b0;
      host_length_nonzero <= 1'b0;
    end else begin
      phase               <= phase_next;
      match_cnt           <= match_cnt_next;
      url_phase           <= url_phase_next;
      url_acc             <= url_acc_next;
      url_seen            <= url_seen_next;
      hdr_acc             <= hdr_acc_next;
      hdr_seen            <= hdr_seen_next;
      host_length_nonzero <= host_length_nonzero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= DEFAULT_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      default_port <= cfg_data;
    end
  end

  // output queue
  assign pushes    = {2'b0, emit} + {2'b0, finish};
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = queue[rd_ptr];
  assign in_stall  = (count > 3'd2);

  always_ff @(posedge clk) begin
    if (emit && finish) begin
      queue[wr_ptr]        <= host_item;
      queue[wr_ptr + 2'd1] <= summary_item;
    end else if (emit) begin
      queue[wr_ptr] <= host_item;
    end else if (finish) begin
      queue[wr_ptr] <= summary_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + pushes[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + pushes - {2'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("output queue overflow");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish |=> (phase == PH_METHOD && !host_length_nonzero && url_phase == URL_SCAN))
    else $error("parse state not cleared after request end");

  a_host_phase: assert property (@(posedge clk) disable iff (rst)
    host_length_nonzero |-> (phase == PH_HOST_NAME || phase == PH_HOST_PORT ||
                             phase == PH_DONE))
    else $error("host seen outside host phases");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (emit || finish) |-> (count <= 3'd2))
    else $error("item accepted without queue room");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_host_port_extractor. Hand-built and random
// HTTP requests go in one byte per item. A parser model in the bench predicts
// the host bytes and the port summaries, and a scoreboard checks every output
// item in order.
// ----------------------------------------------------------------------------
module tb;
  import hhpe_pkg::*;

  localparam int LONG_HOLD = 300;

  class host_port_scoreboard;
    logic [15:0] default_port;
    phase_t      phase;
    url_phase_t  url_phase;
    logic [2:0]  tag_count;
    logic [15:0] url_port;
    logic [15:0] hdr_port;
    bit          url_given, url_sat, url_digits;
    bit          hdr_given, hdr_sat, hdr_digits;
    bit          host_seen;
    out_item_t   expected_items[$];
    int          mismatches;

    function new();
      default_port = DEFAULT_PORT_RESET;
      mismatches = 0;
      start_request();
    endfunction

    function void start_request();
      phase = PH_METHOD;
      url_phase = URL_SCAN;
      tag_count = 3'd0;
      url_port = 16'd0;
      hdr_port = 16'd0;
      url_given = 1'b0;
      url_sat = 1'b0;
      url_digits = 1'b1;
      hdr_given = 1'b0;
      hdr_sat = 1'b0;
      hdr_digits = 1'b1;
      host_seen = 1'b0;
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function bit ends_host(logic [7:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR ||
             c == CH_NUL || c == CH_COLON;
    endfunction

    function logic [7:0] tag_at(logic [2:0] i);
      case (i)
        3'd0: return CH_LF;
        3'd1: return 8'h48;
        3'd2: return 8'h6f;
        3'd3: return 8'h73;
        3'd4: return 8'h74;
        default: return CH_COLON;
      endcase
    endfunction

    // leading decimal digits only, clamped at 65535
    function void add_port_digit(logic [7:0] c, inout logic [15:0] val,
                                 inout bit digits, inout bit sat);
      int v;
      if (!digits) return;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = int'(val) * 10 + int'(c) - 48;
        if (v > 65535) begin
          v = 65535;
          sat = 1'b1;
        end
        val = v[15:0];
      end else begin
        digits = 1'b0;
      end
    endfunction

    function bit parse_byte(logic [7:0] c, output logic [7:0] name_char);
      name_char = CH_NUL;
      if (phase == PH_METHOD) begin
        if (c == CH_SPACE) phase = PH_TO_URL;
        return 1'b0;
      end
      if (phase == PH_TO_URL) begin
        if (!alpha(c)) return 1'b0;
        phase = PH_SEARCH;
      end
      case (url_phase)
        URL_SCAN: begin
          if (c == CH_SPACE) url_phase = URL_DONE;
          else if (c == CH_COLON) url_phase = URL_PORT;
        end
        URL_PORT: begin
          if (c == CH_SPACE || c == CH_SLASH || c == CH_BSLASH) begin
            url_phase = URL_DONE;
          end else begin
            url_given = 1'b1;
            add_port_digit(c, url_port, url_digits, url_sat);
          end
        end
        default: ;
      endcase
      case (phase)
        PH_SEARCH: begin
          if (c == CH_LF) begin
            tag_count = 3'd1;
          end else if (tag_count < TAG_LEN && c == tag_at(tag_count)) begin
            tag_count = tag_count + 3'd1;
            if (tag_count == TAG_LEN) begin
              tag_count = 3'd0;
              phase = PH_HOST_SKIP;
            end
          end else begin
            tag_count = 3'd0;
          end
        end
        PH_HOST_SKIP: begin
          if (alpha(c)) begin
            phase = PH_HOST_NAME;
            host_seen = 1'b1;
            name_char = c;
            return 1'b1;
          end
        end
        PH_HOST_NAME: begin
          if (ends_host(c)) begin
            if (c == CH_COLON) phase = PH_HOST_PORT;
            else phase = PH_DONE;
          end else begin
            host_seen = 1'b1;
            name_char = c;
            return 1'b1;
          end
        end
        PH_HOST_PORT: begin
          if (ends_host(c)) begin
            phase = PH_DONE;
          end else begin
            hdr_given = 1'b1;
            add_port_digit(c, hdr_port, hdr_digits, hdr_sat);
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_item(in_item_t it);
      out_item_t  r;
      logic [7:0] hc;
      int         n0;
      n0 = expected_items.size();
      if (it.byte_value != CH_NUL) begin
        if (parse_byte(it.byte_value, hc)) begin
          r = '0;
          r.kind = KIND_HOST;
          r.host_byte = hc;
          expected_items.push_back(r);
        end
      end
      if (it.byte_value == CH_NUL || it.last) begin
        r = '0;
        r.kind = KIND_SUMMARY;
        if (host_seen) begin
          r.host_found = 1'b1;
          if (hdr_given) begin
            r.port = hdr_port;
            r.port_saturated = hdr_sat;
          end else if (url_given) begin
            r.port = url_port;
            r.port_saturated = url_sat;
          end else begin
            r.port = default_port;
          end
        end
        expected_items.push_back(r);
        start_request();
      end
      if (expected_items.size() > n0) begin
        r = expected_items.pop_back();
        r.end_of_run = 1'b1;
        expected_items.push_back(r);
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected item 0x%0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_items.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("host_byte", want.host_byte, got.host_byte);
      field_check("port", want.port, got.port);
      field_check("host_found", want.host_found, got.host_found);
      field_check("port_saturated", want.port_saturated, got.port_saturated);
      field_check("end_of_run", want.end_of_run, got.end_of_run);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  int          idle_odds = 4;
  int          bytes_sent = 0;
  logic [7:0]  req[$];
  host_port_scoreboard sb;

  http_host_port_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // output side: short stall bursts, calm stretches, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1)) return 8'h41 + 8'($urandom_range(0, 25));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 5))
      0: return CH_SLASH;
      1: return CH_SPACE;
      2: return CH_TAB;
      3: return 8'h2e;
      4: return 8'h2d;
      default: return any_digit();
    endcase
  endfunction

  function automatic logic [7:0] host_char();
    case ($urandom_range(0, 4))
      0, 1: return any_letter();
      2: return any_digit();
      3: return 8'h2e;
      default: return 8'h2d;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    req.push_back(CH_CR);
    req.push_back(CH_LF);
  endfunction

  function automatic void add_port_text();
    case ($urandom_range(0, 5))
      0: add_text("65535");
      1: add_text("65536");
      default: repeat ($urandom_range(0, 7)) req.push_back(any_digit());
    endcase
    if ($urandom_range(0, 3) == 0) begin
      req.push_back(8'h78);
      repeat ($urandom_range(0, 2)) req.push_back(any_digit());
    end
  endfunction

  function automatic void add_other_header();
    add_crlf();
    repeat ($urandom_range(1, 5)) req.push_back(any_letter());
    add_text(": ");
    repeat ($urandom_range(0, 6)) req.push_back(host_char());
  endfunction

  function automatic void build_request();
    repeat ($urandom_range(1, 6)) req.push_back(any_letter());
    req.push_back(CH_SPACE);
    repeat ($urandom_range(0, 2)) req.push_back(junk_char());
    req.push_back(any_letter());
    repeat ($urandom_range(0, 8)) req.push_back(host_char());
    if ($urandom_range(0, 1)) begin
      req.push_back(CH_COLON);
      add_port_text();
      case ($urandom_range(0, 2))
        0: begin
          req.push_back(CH_SLASH);
          req.push_back(any_letter());
        end
        1: req.push_back(CH_BSLASH);
        default: ;
      endcase
    end
    add_text(" HTTP/1.1");
    repeat ($urandom_range(0, 2)) add_other_header();
    add_crlf();
    case ($urandom_range(0, 9))
      0: add_text("Hos:");
      1: add_text("host:");
      2: add_text("Host x");
      3: add_text("Accept: */*");
      default: begin
        add_text("Host:");
        repeat ($urandom_range(0, 2)) req.push_back(junk_char());
        req.push_back(any_letter());
        repeat ($urandom_range(0, 8)) req.push_back(host_char());
        if ($urandom_range(0, 2) == 0) begin
          req.push_back(CH_COLON);
          add_port_text();
        end
        case ($urandom_range(0, 3))
          0: req.push_back(CH_SPACE);
          1: req.push_back(CH_TAB);
          2: ;
          default: add_crlf();
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) add_other_header();
    if ($urandom_range(0, 1)) begin
      add_crlf();
      add_crlf();
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    in_item_t it;
    it.byte_value = b;
    it.last = fin;
    if (!quiet && idle_odds > 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    bytes_sent++;
  endtask

  task automatic send_queued(bit with_last);
    for (int i = 0; i < req.size(); i++) send_byte(req[i], with_last && i == req.size() - 1);
    req.delete();
  endtask

  task automatic random_request();
    int mode;
    int cut;
    mode = $urandom_range(0, 19);
    idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
    if (mode < 3) begin
      repeat ($urandom_range(1, 16)) req.push_back(8'($urandom_range(0, 255)));
      send_queued(1'b1);
    end else begin
      build_request();
      if ($urandom_range(0, 9) == 0) begin
        req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(1, 255));
      end
      if (mode < 14) begin
        send_queued(1'b1);
      end else if (mode < 18) begin
        send_queued(1'b0);
        send_byte(CH_NUL, 1'($urandom_range(0, 1)));
      end else begin
        cut = $urandom_range(1, req.size());
        while (req.size() > cut) void'(req.pop_back());
        send_queued(1'b1);
      end
    end
  endtask

  task automatic write_default_port(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.default_port = v;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_items.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int goal;
    logic [15:0] dport;
    sb = new();
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_default_port(16'hffff);
    // URL port saturates and wins; default port with NUL plus last; no host
    add_text("G u:99999\nHost:x");
    send_queued(1'b1);
    add_text("G a\nHost:b");
    send_queued(1'b0);
    send_byte(CH_NUL, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(CH_NUL, 1'b0);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: dport = 16'd0;
        2: dport = 16'd80;
        default: dport = 16'($urandom_range(0, 65535));
      endcase
      write_default_port(dport);
      if (p == 1) hold_request = 1'b1;
      if (p == 3) quiet = 1'b1;
      goal = bytes_sent + 480;
      while (bytes_sent < goal) random_request();
      settle();
    end

    if (sb.mismatches == 0 && sb.expected_items.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
